FILE: rtl/stkn_pkg.sv
// Shared constants, token kinds and keyword/symbol tables for the source tokenizer
package stkn_pkg;

	localparam int KW_MAX_LEN_DEF   = 11;
	localparam int OFFSET_WIDTH_DEF = 20;
	localparam int NUM_KW           = 17;
	localparam int KW_TEXT_BYTES    = 16;

	localparam logic [15:0] LIMIT_RESET = 16'd32767;
	localparam logic [15:0] SAT16       = 16'hFFFF;

	// token kinds
	localparam logic [5:0] K_END      = 6'd0;
	localparam logic [5:0] K_ERROR    = 6'd1;
	localparam logic [5:0] K_SYM0     = 6'd2;
	localparam logic [5:0] K_DIVIDE   = 6'd20;
	localparam logic [5:0] K_KEYWORD0 = 6'd21;
	localparam logic [5:0] K_NUMBER   = 6'd38;
	localparam logic [5:0] K_IDENT    = 6'd39;

	// characters with special meaning
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;

	// keyword text, right justified, first character in the highest used byte
	localparam logic [8*KW_TEXT_BYTES-1:0] KW_TEXT [NUM_KW] = '{
		"class", "constructor", "method", "function", "var", "static", "field",
		"let", "do", "if", "else", "while", "return", "true", "false", "null", "this"
	};
	localparam logic [7:0] KW_LEN [NUM_KW] = '{
		8'd5, 8'd11, 8'd6, 8'd8, 8'd3, 8'd6, 8'd5, 8'd3, 8'd2, 8'd2,
		8'd4, 8'd5, 8'd6, 8'd4, 8'd5, 8'd4, 8'd4
	};

	// one-character symbols, returns hit and kind
	function automatic logic [6:0] sym_lookup(input logic [7:0] b);
		logic [6:0] r;
		r = '0;
		case (b)
			"+": r = {1'b1, 6'd2};
			"-": r = {1'b1, 6'd3};
			"*": r = {1'b1, 6'd4};
			"&": r = {1'b1, 6'd5};
			"|": r = {1'b1, 6'd6};
			"~": r = {1'b1, 6'd7};
			"<": r = {1'b1, 6'd8};
			">": r = {1'b1, 6'd9};
			"(": r = {1'b1, 6'd10};
			")": r = {1'b1, 6'd11};
			"[": r = {1'b1, 6'd12};
			"]": r = {1'b1, 6'd13};
			"{": r = {1'b1, 6'd14};
			"}": r = {1'b1, 6'd15};
			".": r = {1'b1, 6'd16};
			",": r = {1'b1, 6'd17};
			"=": r = {1'b1, 6'd18};
			";": r = {1'b1, 6'd19};
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic is_dig(input logic [7:0] b);
		return (b >= "0") && (b <= "9");
	endfunction

	function automatic logic is_alp(input logic [7:0] b);
		return ((b >= "A") && (b <= "Z")) || ((b >= "a") && (b <= "z")) || (b == "_");
	endfunction

endpackage

FILE: rtl/stkn_kw_match.sv
// Keyword matcher: compares the held word against the keyword table
module stkn_kw_match import stkn_pkg::*; #(
	parameter int KEYWORD_MAX_LEN = KW_MAX_LEN_DEF
) (
	input  logic [KEYWORD_MAX_LEN-1:0][7:0] chars,
	input  logic [7:0]                      len,
	output logic                            hit,
	output logic [5:0]                      kind
);

	// parallel compare over all keywords, first match wins
	always_comb begin
		logic eq;
		logic [7:0] kb;
		hit  = 1'b0;
		kind = K_IDENT;
		for (int k = NUM_KW - 1; k >= 0; k--) begin
			eq = (len == KW_LEN[k]) && (len <= 8'(KEYWORD_MAX_LEN));
			for (int i = 0; i < KEYWORD_MAX_LEN; i++) begin
				if (i < int'(KW_LEN[k])) begin
					kb = KW_TEXT[k][(int'(KW_LEN[k]) - 1 - i) * 8 +: 8];
					if (chars[i] != kb) eq = 1'b0;
				end
			end
			if (eq) begin
				hit  = 1'b1;
				kind = K_KEYWORD0 + 6'(k);
			end
		end
	end

endmodule

FILE: rtl/source_tokenizer_top.sv
// Source tokenizer top level: byte scanner and result queue
//
// channel  direction  handshake            payload
// in       input      in_valid/in_stall    op, text_byte
// out      output     out_valid/out_stall  token_kind .. last_of_run
// cfg      input      number_limit_we      number_limit_wdata
//
// One byte is scanned per cycle; each byte yields zero, one or two tokens
// that go into a four-entry result queue, drained one token per cycle.
// Bytes are taken while the queue holds at most two tokens, so the scanner
// runs at one byte per cycle unless the output side stalls or bursts of
// two-token bytes outpace the one-token-per-cycle drain.
// Reset clears the scanner and empties the queue; the limit returns to 32767.
module source_tokenizer_top import stkn_pkg::*; #(
	parameter int KEYWORD_MAX_LEN = KW_MAX_LEN_DEF,
	parameter int OFFSET_WIDTH    = OFFSET_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    number_limit_we,
	input  logic [15:0]             number_limit_wdata,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    op,
	input  logic [7:0]              text_byte,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [5:0]              token_kind,
	output logic [15:0]             number_value,
	output logic [OFFSET_WIDTH-1:0] lexeme_offset,
	output logic [7:0]              lexeme_length,
	output logic [15:0]             line_number,
	output logic                    last_of_run
);

	localparam int IDX_W = $clog2(KEYWORD_MAX_LEN);

	typedef enum logic [2:0] {
		M_IDLE, M_WORD, M_SLASH, M_LINE, M_BLOCK, M_STAR, M_HALT
	} mode_t;

	typedef struct packed {
		logic [5:0]              kind;
		logic [15:0]             value;
		logic [OFFSET_WIDTH-1:0] offset;
		logic [7:0]              len;
		logic [15:0]             line;
		logic                    last;
	} tok_t;

	mode_t                                 mode_q, mode_d;
	logic [KEYWORD_MAX_LEN-1:0][7:0]       chars_q;
	logic [7:0]                            wlen_q, wlen_d;
	logic                                  alld_q, alld_d;
	logic                                  salp_q, salp_d;
	logic [15:0]                           acc_q, acc_d;
	logic [OFFSET_WIDTH-1:0]               off_q, off_d;
	logic [OFFSET_WIDTH-1:0]               wstart_q, wstart_d;
	logic [15:0]                           line_q, line_d;
	logic [15:0]                           limit_q;

	logic       ch_we;
	logic [IDX_W-1:0] ch_idx;
	logic       accept;
	logic       kw_hit;
	logic [5:0] kw_kind;
	tok_t       word_tok;
	tok_t       toks [2];
	logic [1:0] ntok;

	stkn_kw_match #(.KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)) u_kw (
		.chars (chars_q),
		.len   (wlen_q),
		.hit   (kw_hit),
		.kind  (kw_kind)
	);

	assign accept = in_valid && !in_stall;

	// token for the word being held
	always_comb begin
		word_tok        = '0;
		word_tok.offset = wstart_q;
		word_tok.len    = wlen_q;
		word_tok.line   = line_q;
		if (alld_q) begin
			word_tok.kind  = K_NUMBER;
			word_tok.value = (acc_q > limit_q) ? limit_q : acc_q;
		end else if (!salp_q) begin
			word_tok.kind = K_ERROR;
		end else if (kw_hit) begin
			word_tok.kind = kw_kind;
		end else begin
			word_tok.kind = K_IDENT;
		end
	end

	// scanner next state and tokens for one request
	always_comb begin
		logic       do_idle, start_w, add_b, bump;
		logic [6:0] sym;
		logic [7:0] b, lbase;
		logic [19:0] mac;
		tok_t       t;
		b        = text_byte;
		do_idle  = 1'b0;
		start_w  = 1'b0;
		add_b    = 1'b0;
		bump     = 1'b0;
		mode_d   = mode_q;
		wlen_d   = wlen_q;
		alld_d   = alld_q;
		salp_d   = salp_q;
		acc_d    = acc_q;
		wstart_d = wstart_q;
		line_d   = line_q;
		off_d    = off_q + 1'b1;
		ch_we    = 1'b0;
		ch_idx   = '0;
		ntok     = '0;
		toks[0]  = '0;
		toks[1]  = '0;
		sym      = sym_lookup(b);
		mac      = '0;
		lbase    = '0;
		t        = '0;

		if (op) begin
			// flush pending token, then end token, then clear
			if (mode_q == M_WORD) begin
				toks[0] = word_tok;
				ntok    = 2'd1;
			end else if (mode_q == M_SLASH) begin
				t        = '0;
				t.kind   = K_DIVIDE;
				t.offset = wstart_q;
				t.len    = 8'd1;
				t.line   = line_q;
				toks[0]  = t;
				ntok     = 2'd1;
			end
			t        = '0;
			t.kind   = K_END;
			t.offset = off_q;
			t.line   = line_q;
			toks[ntok[0]] = t;
			ntok     = ntok + 2'd1;
			mode_d   = M_IDLE;
			wlen_d   = '0;
			alld_d   = 1'b1;
			salp_d   = 1'b0;
			acc_d    = '0;
			off_d    = '0;
			wstart_d = '0;
			line_d   = 16'd1;
		end else begin
			unique case (mode_q)
				M_HALT: begin
				end
				M_WORD: begin
					if (is_alp(b) || is_dig(b)) begin
						add_b = 1'b1;
					end else begin
						toks[0] = word_tok;
						ntok    = 2'd1;
						mode_d  = M_IDLE;
						do_idle = 1'b1;
					end
				end
				M_SLASH: begin
					if (b == CH_SLASH) begin
						mode_d = M_LINE;
					end else if (b == CH_STAR) begin
						mode_d = M_BLOCK;
					end else begin
						t.kind   = K_DIVIDE;
						t.offset = wstart_q;
						t.len    = 8'd1;
						t.line   = line_q;
						toks[0]  = t;
						ntok     = 2'd1;
						mode_d   = M_IDLE;
						do_idle  = 1'b1;
					end
				end
				M_LINE: begin
					if (b == CH_LF) begin
						bump   = 1'b1;
						mode_d = M_IDLE;
					end
				end
				M_BLOCK: begin
					if (b == CH_STAR) mode_d = M_STAR;
					else if (b == CH_LF) bump = 1'b1;
				end
				M_STAR: begin
					if (b == CH_SLASH) begin
						mode_d = M_IDLE;
					end else if (b != CH_STAR) begin
						bump   = (b == CH_LF);
						mode_d = M_BLOCK;
					end
				end
				default: begin
					mode_d  = M_IDLE;
					do_idle = 1'b1;
				end
			endcase

			// handling of a byte from the idle mode
			if (do_idle) begin
				t        = '0;
				t.offset = off_q;
				t.len    = 8'd1;
				t.line   = line_q;
				if (b == CH_SPACE || b == CH_TAB || b == CH_CR) begin
				end else if (b == CH_LF) begin
					bump = 1'b1;
				end else if (sym[6]) begin
					t.kind        = sym[5:0];
					toks[ntok[0]] = t;
					ntok          = ntok + 2'd1;
				end else if (b == CH_SLASH) begin
					wstart_d = off_q;
					mode_d   = M_SLASH;
				end else if (is_alp(b) || is_dig(b)) begin
					wstart_d = off_q;
					start_w  = 1'b1;
					add_b    = 1'b1;
					salp_d   = is_alp(b);
					mode_d   = M_WORD;
				end else begin
					t.kind        = K_ERROR;
					toks[ntok[0]] = t;
					ntok          = ntok + 2'd1;
					mode_d        = M_HALT;
				end
			end

			// append a character to the word
			if (add_b) begin
				lbase  = start_w ? 8'd0 : wlen_q;
				alld_d = start_w ? 1'b1 : alld_q;
				acc_d  = start_w ? 16'd0 : acc_q;
				ch_we  = lbase < 8'(KEYWORD_MAX_LEN);
				ch_idx = lbase[IDX_W-1:0];
				wlen_d = (lbase == 8'hFF) ? lbase : lbase + 8'd1;
				if (is_dig(b)) begin
					mac   = 20'(acc_d) * 20'd10 + 20'(b - "0");
					acc_d = (mac > 20'(SAT16)) ? SAT16 : mac[15:0];
				end else begin
					alld_d = 1'b0;
				end
			end

			if (bump && line_q != SAT16) line_d = line_q + 16'd1;
		end

		// mark the last token of this request
		if (ntok == 2'd1) toks[0].last = 1'b1;
		if (ntok == 2'd2) toks[1].last = 1'b1;
	end

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			wlen_q   <= '0;
			alld_q   <= 1'b1;
			salp_q   <= 1'b0;
			acc_q    <= '0;
			off_q    <= '0;
			wstart_q <= '0;
			line_q   <= 16'd1;
			limit_q  <= LIMIT_RESET;
		end else begin
			if (number_limit_we) limit_q <= number_limit_wdata;
			if (accept) begin
				mode_q   <= mode_d;
				wlen_q   <= wlen_d;
				alld_q   <= alld_d;
				salp_q   <= salp_d;
				acc_q    <= acc_d;
				off_q    <= off_d;
				wstart_q <= wstart_d;
				line_q   <= line_d;
			end
		end
	end

	// word character store
	always_ff @(posedge clk) begin
		if (accept && ch_we) chars_q[ch_idx] <= text_byte;
	end

	// result queue, four entries
	tok_t       q_mem [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic       pop;
	logic [1:0] push_n;

	assign push_n    = accept ? ntok : 2'd0;
	assign pop       = out_valid && !out_stall;
	assign out_valid = (cnt_q != 3'd0);
	assign in_stall  = (cnt_q > 3'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + push_n;
			rd_q  <= rd_q + 2'(pop);
			cnt_q <= cnt_q + 3'(push_n) - 3'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) q_mem[wr_q] <= toks[0];
		if (push_n == 2'd2) q_mem[wr_q + 2'd1] <= toks[1];
	end

	assign token_kind    = q_mem[rd_q].kind;
	assign number_value  = q_mem[rd_q].value;
	assign lexeme_offset = q_mem[rd_q].offset;
	assign lexeme_length = q_mem[rd_q].len;
	assign line_number   = q_mem[rd_q].line;
	assign last_of_run   = q_mem[rd_q].last;

endmodule

FILE: rtl/stkn_checker.sv
// Port-level checks for the source tokenizer, bound to the top level
module stkn_checker import stkn_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [5:0]  token_kind,
	input logic [15:0] number_value,
	input logic [7:0]  lexeme_length,
	input logic        last_of_run
);

	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped under stall");

	// an empty queue never stalls the input
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall) else $error("input stalled with empty queue");

	// the end token closes its request
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == K_END |-> last_of_run && lexeme_length == 8'd0)
		else $error("bad end token");

	// only numbers carry a value
	a_val: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind != K_NUMBER |-> number_value == 16'd0)
		else $error("value on non-number");

	// every non-end token has a length
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind != K_END |-> lexeme_length != 8'd0)
		else $error("empty token");

endmodule

bind source_tokenizer_top stkn_checker u_stkn_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.token_kind    (token_kind),
	.number_value  (number_value),
	.lexeme_length (lexeme_length),
	.last_of_run   (last_of_run)
);
